// File: rtl/ksia_pkg.sv
// shared types and constants for the keyed slot index allocator
`timescale 1ns / 1ps
package ksia_pkg;
    localparam int MAX_SLOTS = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [1:0] {
        CMD_CLONE  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SELECT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SRC_MISS  = 3'd1,
        ST_TGT_EXIST = 3'd2,
        ST_KEY_MISS  = 3'd3,
        ST_INIT_REM  = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_EXTEND    = 3'd1,
        ACT_RECYCLE   = 3'd2,
        ACT_OVERWRITE = 3'd3,
        ACT_DELETE    = 3'd4,
        ACT_REDUCE    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC_SCAN,
        S_TGT_SCAN,
        S_EXEC,
        S_SHRINK,
        S_OUT
    } t_state;
endpackage

// File: rtl/keyed_slot_index_allocator_top.sv
// keyed slot index allocator: key table in a synchronous memory, scanned per command
//
// Input channel: i_valid/o_stall with command, key, source key and overwrite flag.
// Output channel: o_valid/i_stall, one result beat per accepted command.
// Configuration: i_cfg_we with i_cfg_wdata rekeys slot zero; write only when idle.
// One command is handled at a time. A key lookup reads the key memory one slot per
// cycle and stops at the first hit. A clone runs a source lookup, then a target
// lookup; a remove that frees the top slot then shrinks past the unused slots below
// it; a CMD_NONE goes straight to the result. A stalled receiver holds the result.
// The result stays in an output register; o_stall is high from acceptance until the
// result has been taken, so a stalled receiver holds the block with the beat intact.
// Synchronous active-low reset: slot zero live with key zero, used size one,
// working slot zero selected. Slot zero's key comes from the initial key register,
// stale memory entries are masked by live bits.
`timescale 1ns / 1ps
module keyed_slot_index_allocator_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  ksia_pkg::t_key          i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_command,
    input  ksia_pkg::t_key          i_key,
    input  ksia_pkg::t_key          i_source_key,
    input  logic                    i_may_overwrite,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic [2:0]              o_action,
    output ksia_pkg::t_idx          o_slot_index,
    output ksia_pkg::t_idx          o_source_index,
    output ksia_pkg::t_cnt          o_reduce_count,
    output ksia_pkg::t_cnt          o_used_size,
    output ksia_pkg::t_idx          o_working_index,
    output logic                    o_working_valid
);
    import ksia_pkg::*;

    t_key mem [MAX_SLOTS];
    t_key r_rdata;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_key   r_key, r_src, r_init;
    logic   r_ow;
    logic [MAX_SLOTS-1:0] r_live, n_live, r_unused, n_unused;
    t_cnt   r_used, n_used;
    t_idx   r_wslot, n_wslot;
    logic   r_wset, n_wset;
    t_cnt   r_ptr, n_ptr;      // scan address
    logic   r_rd_ok, n_rd_ok;  // read data belongs to r_ptr - 1
    t_idx   r_hit, n_hit;
    logic   r_found, n_found;
    t_idx   r_sidx, n_sidx;
    t_idx   r_slot, n_slot;
    t_cnt   r_red, n_red;
    t_status r_st, n_st;
    t_action r_act, n_act;
    logic   r_ov, n_ov;

    logic   mem_we;
    t_idx   mem_waddr;
    t_key   mem_wdata;
    t_idx   rd_addr;
    t_idx   prev_idx;
    t_key   cmp_key;
    t_key   scan_key;
    logic   free_any;
    t_idx   free_idx;

    assign rd_addr  = r_ptr[IDX_W-1:0];
    assign prev_idx = t_idx'(r_ptr - t_cnt'(1));
    assign cmp_key  = (r_state == S_SRC_SCAN) ? r_src : r_key;
    assign scan_key = (prev_idx == '0) ? r_init : r_rdata;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (r_unused[i]) begin
                free_any = 1'b1;
                free_idx = t_idx'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= {{(MAX_SLOTS-1){1'b0}}, 1'b1};
            r_unused <= '0;
            r_used  <= t_cnt'(1);
            r_wslot <= '0;
            r_wset  <= 1'b1;
            r_init  <= '0;
            r_ov    <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_unused <= n_unused;
            r_used  <= n_used;
            r_wslot <= n_wslot;
            r_wset  <= n_wset;
            r_ov    <= n_ov;
            r_rd_ok <= n_rd_ok;
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= i_key;
            r_src <= i_source_key;
            r_ow  <= i_may_overwrite;
        end
        r_ptr   <= n_ptr;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_sidx  <= n_sidx;
        r_slot  <= n_slot;
        r_red   <= n_red;
        r_st    <= n_st;
        r_act   <= n_act;
    end

    always_comb begin
        n_state  = r_state;
        n_live   = r_live;
        n_unused = r_unused;
        n_used   = r_used;
        n_wslot  = r_wslot;
        n_wset   = r_wset;
        n_ptr    = r_ptr;
        n_rd_ok  = 1'b0;
        n_hit    = r_hit;
        n_found  = r_found;
        n_sidx   = r_sidx;
        n_slot   = r_slot;
        n_red    = r_red;
        n_st     = r_st;
        n_act    = r_act;
        n_ov     = r_ov;
        mem_we   = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_key;
        if (i_cfg_we) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = i_cfg_wdata;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ptr   = '0;
                    n_found = 1'b0;
                    n_hit   = '0;
                    n_sidx  = '0;
                    n_slot  = '0;
                    n_red   = '0;
                    n_st    = ST_OK;
                    n_act   = ACT_NONE;
                    if (t_cmd'(i_command) == CMD_CLONE) begin
                        n_state = S_SRC_SCAN;
                    end else if (t_cmd'(i_command) == CMD_NONE) begin
                        n_state = S_OUT;
                        n_ov    = 1'b1;
                    end else begin
                        n_state = S_TGT_SCAN;
                    end
                end
            end
            S_SRC_SCAN, S_TGT_SCAN: begin
                // issue address r_ptr, check data of r_ptr - 1
                if (r_rd_ok && !r_found && r_live[prev_idx] && scan_key == cmp_key) begin
                    n_found = 1'b1;
                    n_hit   = prev_idx;
                end
                if (r_ptr < r_used && !n_found) begin
                    n_ptr   = r_ptr + t_cnt'(1);
                    n_rd_ok = 1'b1;
                end else if (r_rd_ok) begin
                    n_rd_ok = 1'b0;
                end else begin
                    if (r_state == S_SRC_SCAN) begin
                        if (!n_found) begin
                            n_st    = ST_SRC_MISS;
                            n_state = S_OUT;
                            n_ov    = 1'b1;
                        end else begin
                            n_sidx  = n_hit;
                            n_ptr   = '0;
                            n_found = 1'b0;
                            n_state = S_TGT_SCAN;
                        end
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                n_ov    = 1'b1;
                case (r_cmd)
                    CMD_CLONE: begin
                        if (r_found) begin
                            if (r_ow) begin
                                n_act  = ACT_OVERWRITE;
                                n_slot = r_hit;
                            end else begin
                                n_st = ST_TGT_EXIST;
                            end
                        end else if (free_any) begin
                            n_unused[free_idx] = 1'b0;
                            n_live[free_idx]   = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = free_idx;
                            n_act  = ACT_RECYCLE;
                            n_slot = free_idx;
                        end else if (r_used < t_cnt'(MAX_SLOTS)) begin
                            n_live[r_used[IDX_W-1:0]] = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = r_used[IDX_W-1:0];
                            n_used = r_used + t_cnt'(1);
                            n_act  = ACT_EXTEND;
                            n_slot = r_used[IDX_W-1:0];
                        end else begin
                            n_st = ST_FULL;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_key == r_init) begin
                            n_st = ST_INIT_REM;
                        end else if (!r_found || r_hit == '0) begin
                            n_st = ST_KEY_MISS;
                        end else begin
                            n_live[r_hit] = 1'b0;
                            n_slot = r_hit;
                            if (r_wslot == r_hit) begin
                                n_wset = 1'b0;
                            end
                            if ({1'b0, r_hit} + t_cnt'(1) == r_used) begin
                                n_act   = ACT_REDUCE;
                                n_red   = t_cnt'(1);
                                n_used  = r_used - t_cnt'(1);
                                n_state = S_SHRINK;
                                n_ov    = 1'b0;
                            end else begin
                                n_unused[r_hit] = 1'b1;
                                n_act = ACT_DELETE;
                            end
                        end
                    end
                    default: begin
                        if (!r_found) begin
                            n_st = ST_KEY_MISS;
                        end else begin
                            n_wslot = r_hit;
                            n_wset  = 1'b1;
                            n_slot  = r_hit;
                        end
                    end
                endcase
            end
            S_SHRINK: begin
                // r_used > 0 always; check slot below the top
                if (r_unused[t_idx'(r_used - t_cnt'(1))]) begin
                    n_unused[t_idx'(r_used - t_cnt'(1))] = 1'b0;
                    n_used = r_used - t_cnt'(1);
                    n_red  = r_red + t_cnt'(1);
                end else begin
                    n_state = S_OUT;
                    n_ov    = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_ov    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ov;
    assign o_status        = r_st;
    assign o_action        = r_act;
    assign o_slot_index    = r_slot;
    assign o_source_index  = r_sidx;
    assign o_reduce_count  = r_red;
    assign o_used_size     = r_used;
    assign o_working_index = r_wslot;
    assign o_working_valid = r_wset;

    a_slot0_live: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_live[0])
        else $error("slot zero not live");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= t_cnt'(1) && r_used <= t_cnt'(MAX_SLOTS))
        else $error("used size out of range");
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == S_OUT)
        else $error("result valid outside output state");
    a_unused_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_unused & r_live) == '0)
        else $error("unused slot still live");
endmodule

// File: verif/testbench.sv
// self-checking testbench for the keyed slot index allocator
`timescale 1ns / 1ps
module testbench;
    import ksia_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] action;
        t_idx       slot_index;
        t_idx       source_index;
        t_cnt       reduce_count;
        t_cnt       used_size;
        t_idx       working_index;
        logic       working_valid;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_key       i_cfg_wdata;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_command;
    t_key       i_key;
    t_key       i_source_key;
    logic       i_may_overwrite;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_status;
    logic [2:0] o_action;
    t_idx       o_slot_index;
    t_idx       o_source_index;
    t_cnt       o_reduce_count;
    t_cnt       o_used_size;
    t_idx       o_working_index;
    logic       o_working_valid;

    keyed_slot_index_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_key(i_key), .i_source_key(i_source_key),
        .i_may_overwrite(i_may_overwrite),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_action(o_action), .o_slot_index(o_slot_index),
        .o_source_index(o_source_index), .o_reduce_count(o_reduce_count),
        .o_used_size(o_used_size), .o_working_index(o_working_index),
        .o_working_valid(o_working_valid)
    );

    // allocator mirror
    t_key   tbl_key [MAX_SLOTS];
    logic   tbl_live [MAX_SLOTS];
    logic   tbl_free [MAX_SLOTS];
    t_key   init_key;
    int     used_cnt;
    int     work_slot;
    logic   work_set;

    t_result pending_results[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int lookup_slot(t_key k);
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (tbl_live[i] && tbl_key[i] == k) return i;
        end
        return -1;
    endfunction

    task automatic mirror_reset();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_live[i] = 1'b0;
            tbl_free[i] = 1'b0;
        end
        init_key = '0;
        tbl_live[0] = 1'b1;
        used_cnt = 1;
        work_slot = 0;
        work_set = 1'b1;
    endtask

    function automatic t_result allocate(t_cmd cmd, t_key k, t_key src, logic ovw);
        t_result r;
        int s;
        int t;
        int fr;
        int cnt;
        r = '0;
        r.status = ST_OK;
        r.action = ACT_NONE;
        if (cmd == CMD_CLONE) begin
            s = lookup_slot(src);
            if (s < 0) begin
                r.status = ST_SRC_MISS;
            end else begin
                r.source_index = t_idx'(s);
                t = lookup_slot(k);
                if (t >= 0) begin
                    if (ovw) begin
                        r.action = ACT_OVERWRITE;
                        r.slot_index = t_idx'(t);
                    end else begin
                        r.status = ST_TGT_EXIST;
                    end
                end else begin
                    fr = -1;
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (fr < 0 && tbl_free[i]) fr = i;
                    end
                    if (fr >= 0) begin
                        tbl_free[fr] = 1'b0;
                        tbl_key[fr] = k;
                        tbl_live[fr] = 1'b1;
                        r.action = ACT_RECYCLE;
                        r.slot_index = t_idx'(fr);
                    end else if (used_cnt < MAX_SLOTS) begin
                        r.slot_index = t_idx'(used_cnt);
                        tbl_key[used_cnt] = k;
                        tbl_live[used_cnt] = 1'b1;
                        used_cnt++;
                        r.action = ACT_EXTEND;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
        end else if (cmd == CMD_REMOVE) begin
            if (k == init_key) begin
                r.status = ST_INIT_REM;
            end else begin
                t = lookup_slot(k);
                if (t <= 0) begin
                    r.status = ST_KEY_MISS;
                end else begin
                    tbl_live[t] = 1'b0;
                    r.slot_index = t_idx'(t);
                    if (t + 1 == used_cnt) begin
                        cnt = 1;
                        for (int j = t; j > 0 && tbl_free[j-1]; j--) begin
                            tbl_free[j-1] = 1'b0;
                            cnt++;
                        end
                        used_cnt -= cnt;
                        r.reduce_count = t_cnt'(cnt);
                        r.action = ACT_REDUCE;
                    end else begin
                        tbl_free[t] = 1'b1;
                        r.action = ACT_DELETE;
                    end
                    if (work_slot == t) work_set = 1'b0;
                end
            end
        end else if (cmd == CMD_SELECT) begin
            t = lookup_slot(k);
            if (t < 0) begin
                r.status = ST_KEY_MISS;
            end else begin
                work_slot = t;
                work_set = 1'b1;
                r.slot_index = t_idx'(t);
            end
        end
        r.used_size = t_cnt'(used_cnt);
        r.working_index = t_idx'(work_slot);
        r.working_valid = work_set;
        return r;
    endfunction

    // valid stays high across back-to-back beats and drops only in idle cycles
    task automatic send_command(t_cmd cmd, t_key k, t_key src, logic ovw);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_key <= k;
        i_source_key <= src;
        i_may_overwrite <= ovw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(allocate(cmd, k, src, ovw));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_initial_key(t_key k);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        init_key = k;
        tbl_key[0] = k;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_action, o_slot_index, o_source_index, o_reduce_count,
                    o_used_size, o_working_index, o_working_valid};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) $display("unexpected beat %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: expected st%0d act%0d sl%0d src%0d red%0d sz%0d wk%0d/%0d",
                                 want.status, want.action, want.slot_index, want.source_index,
                                 want.reduce_count, want.used_size, want.working_index,
                                 want.working_valid);
                        $display("          actual   st%0d act%0d sl%0d src%0d red%0d sz%0d wk%0d/%0d",
                                 got.status, got.action, got.slot_index, got.source_index,
                                 got.reduce_count, got.used_size, got.working_index,
                                 got.working_valid);
                    end
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_key pick_key(int pool);
        // mostly a small key pool so lookups hit, sometimes wide random keys
        if ($urandom_range(9) == 0) return t_key'($urandom());
        return t_key'($urandom_range(pool));
    endfunction

    task automatic test_directed();
        send_command(CMD_SELECT, 32'h0, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'h0, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'h5, 32'h0, 1'b0);
        send_command(CMD_CLONE, 32'h1, 32'h7, 1'b0);
        for (int i = 1; i < MAX_SLOTS; i++) begin
            send_command(CMD_CLONE, t_key'(i), 32'h0, 1'b0);
        end
        send_command(CMD_CLONE, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_command(CMD_CLONE, 32'h3, 32'h3, 1'b1);
        send_command(CMD_CLONE, 32'h3, 32'h2, 1'b0);
        send_command(CMD_CLONE, 32'h0, 32'hF, 1'b1);
        send_command(CMD_SELECT, 32'hE, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'hE, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'hD, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'hF, 32'h0, 1'b0);
        send_command(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_CLONE, 32'hAAAA_5555, 32'hC, 1'b0);
    endtask

    task automatic test_random(int count, int pool);
        int c;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(99);
            if (c < 45) begin
                send_command(CMD_CLONE, pick_key(pool), pick_key(pool), 1'($urandom()));
            end else if (c < 80) begin
                send_command(CMD_REMOVE, pick_key(pool), t_key'($urandom()), 1'($urandom()));
            end else if (c < 96) begin
                send_command(CMD_SELECT, pick_key(pool), t_key'($urandom()), 1'($urandom()));
            end else begin
                send_command(CMD_NONE, t_key'($urandom()), t_key'($urandom()), 1'($urandom()));
            end
        end
    endtask

    task automatic test_duplicate_initial();
        // rekey slot zero onto a live key so lookups must return the lowest slot
        send_command(CMD_CLONE, 32'h9, 32'h0, 1'b0);
        write_initial_key(32'h9);
        send_command(CMD_SELECT, 32'h9, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'h9, 32'h0, 1'b0);
        send_command(CMD_CLONE, 32'h9, 32'h9, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(30, 20);
        wait_drained();
        test_random(10, 20);
    endtask

    initial begin
        mismatches = 0;
        send_idle_pct = 17;
        recv_idle_pct = 84;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_command = CMD_NONE;
        i_key = '0;
        i_source_key = '0;
        i_may_overwrite = 1'b0;
        mirror_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250, 24);
        test_duplicate_initial();
        write_initial_key(32'hFFFF_FFFF);
        send_idle_pct = 84;
        recv_idle_pct = 17;
        test_random(300, 30);
        test_backpressure();
        write_initial_key(32'h5A5A_A5A5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450, 40);
        write_initial_key(32'h0);
        test_random(60, 18);
        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/ksia_pkg.sv
rtl/keyed_slot_index_allocator_top.sv
verif/testbench.sv
